>>> rtl/core/weighted_kmeans_1d_intensity_core_defines.svh
// assertion macros shared by the weighted k-means core
`ifndef WEIGHTED_KMEANS_1D_INTENSITY_CORE_DEFINES_SVH
`define WEIGHTED_KMEANS_1D_INTENSITY_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, disabled during reset
`define WKM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wkm check failed");

// next-cycle implication, checked on clk, disabled during reset
`define WKM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wkm check failed");

`endif

>>> rtl/core/wkm_pkg.sv
// shared types and constants of the weighted k-means core
package wkm_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int K_MAX      = 4;
  localparam int PIXEL_BITS = 16;
  localparam int MEAN_W     = 24;
  localparam int SUM_W      = 32;
  localparam int DIVD_W     = SUM_W + 8;
  localparam int DIVS_W     = CNT_W;
  localparam int DELTA_W    = 27;
  localparam int CFG_W      = 26;

  localparam logic [2:0] CFG_NUM_CLUSTERS = 3'd0;
  localparam logic [2:0] CFG_WEIGHT_ZERO  = 3'd1;
  localparam logic [2:0] CFG_WEIGHT_ONE   = 3'd2;
  localparam logic [2:0] CFG_WEIGHT_TWO   = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_THREE = 3'd4;
  localparam logic [2:0] CFG_CONV_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_MAX_PASSES   = 3'd6;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_MASKED = 2'd2;

  typedef enum logic [4:0] {
    S_LOAD,
    S_STAT,
    S_STAT_END,
    S_INIT_DIV,
    S_INIT_SET,
    S_PASS_START,
    S_SCAN_RD,
    S_SCAN_WAIT,
    S_SQ,
    S_MUL,
    S_CMP,
    S_ACC,
    S_CHECK,
    S_UPD_DIV,
    S_UPD_WAIT,
    S_CONV,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/core/wkm_pixel_ram.sv
// pixel store: one write port, one registered read port
module wkm_pixel_ram
  import wkm_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [PIXEL_BITS:0]   wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [PIXEL_BITS:0]   rdata
);

  logic [PIXEL_BITS:0] mem [MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/wkm_div.sv
// restoring divider, one quotient bit per cycle
module wkm_div
  import wkm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  `include "weighted_kmeans_1d_intensity_core_defines.svh"

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DIVS_W-1:0] divisor;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W:0]   trial;

  assign trial = {rem, quotient[DIVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      divisor  <= req.divisor;
      quotient <= req.dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem      <= DIVS_W'(trial - {1'b0, divisor});
        quotient <= {quotient[DIVD_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b0};
      end
    end
  end

  `WKM_ASSERT_NOW(a_start_idle, req.start, !busy)
  `WKM_ASSERT_NEXT(a_start_busy, req.start, busy && !done)
  `WKM_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

>>> rtl/core/weighted_kmeans_1d_intensity_core.sv
// top level of the weighted one-dimensional k-means core
// Pixels are taken one transaction per cycle into a 65536-entry store until a
// transaction flagged last_pixel; pixels past the store depth are dropped but
// the flag still starts the run. The run then works out of the store through
// its single read port: a statistics sweep over the stored pixels, one divide
// for the initial means, and then each pass reads every stored pixel again,
// with a square, a weight multiply and a compare per cluster for an unmasked
// pixel and none for a masked one, followed by k divides for the new means.
// Results leave through an output register, one transaction per cluster, or a
// single error transaction; no new pixel is taken until the last result of a
// run is in that register.
module weighted_kmeans_1d_intensity_core
  import wkm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] pixel_value,
  input  logic                  masked_out,
  input  logic                  last_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            cluster_index,
  output logic [MEAN_W-1:0]     cluster_mean,
  output logic [7:0]            passes_done,
  output logic [1:0]            status,
  output logic                  last_result
);

  `include "weighted_kmeans_1d_intensity_core_defines.svh"

  // configuration registers
  logic [2:0]         num_clusters;
  logic [15:0]        weights [K_MAX];
  logic [CFG_W-1:0]   conv_limit;
  logic [7:0]         max_passes;

  state_t state, state_next;

  // run state
  logic [CNT_W-1:0]   pixel_count;
  logic [CNT_W-1:0]   idx;
  logic               rvalid;
  logic [CNT_W-1:0]   n_unmasked;
  logic [SUM_W-1:0]   stat_sum;
  logic [PIXEL_BITS-1:0] mn, mx;
  logic [MEAN_W-1:0]  means [K_MAX];
  logic [MEAN_W-1:0]  prev  [K_MAX];
  logic [SUM_W-1:0]   sums  [K_MAX];
  logic [CNT_W-1:0]   counts [K_MAX];
  logic [7:0]         pass;
  logic [1:0]         j;
  logic [1:0]         best;
  logic [63:0]        bd;
  logic [PIXEL_BITS-1:0] pix;
  logic [47:0]        sq;
  logic [39:0]        plo, phi;
  logic [DELTA_W-1:0] delta;
  logic [1:0]         err_index;
  logic [7:0]         err_passes;
  logic [1:0]         err_status;

  logic [2:0]         k_eff;
  logic               k_is_two;
  logic               j_last;
  logic               in_accept;
  logic               out_free;
  logic               out_load;
  logic [PIXEL_BITS:0] ram_rdata;
  logic [ADDR_W-1:0]  ram_raddr;
  div_req_t           div_req;
  logic               div_done;
  logic [DIVD_W-1:0]  div_q;
  logic               any_empty;
  logic [1:0]         first_empty;
  logic [MEAN_W-1:0]  lo, hi;
  logic [MEAN_W-1:0]  pf;
  logic [MEAN_W-1:0]  abs_diff;
  logic [63:0]        nd;
  logic [MEAN_W-1:0]  new_mean;
  logic [MEAN_W-1:0]  mean_diff;
  logic [MEAN_W-1:0]  avg, step;

  // cluster count outside 2..K_MAX is clamped
  always_comb begin
    if (num_clusters < 3'd2) begin
      k_eff = 3'd2;
    end else if (num_clusters > 3'(K_MAX)) begin
      k_eff = 3'(K_MAX);
    end else begin
      k_eff = num_clusters;
    end
  end

  assign k_is_two  = (k_eff == 3'd2);
  assign j_last    = ({1'b0, j} == k_eff - 3'd1);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state == S_EMIT || state == S_ERR);
  assign ram_raddr = idx[ADDR_W-1:0];
  assign lo        = {mn, 8'd0};
  assign hi        = {mx, 8'd0};
  assign pf        = {pix, 8'd0};
  assign abs_diff  = (pf > prev[j]) ? pf - prev[j] : prev[j] - pf;
  assign nd        = {24'd0, plo} + {phi, 24'd0};
  assign new_mean  = div_q[MEAN_W-1:0];
  assign mean_diff = (new_mean > prev[j]) ? new_mean - prev[j] : prev[j] - new_mean;
  assign avg       = div_q[MEAN_W-1:0];
  assign step      = div_q[MEAN_W-1:0];

  // lowest empty cluster among those in use
  always_comb begin
    any_empty   = 1'b0;
    first_empty = '0;
    for (int c = K_MAX - 1; c >= 0; c--) begin
      if (3'(c) < k_eff && counts[c] == '0) begin
        any_empty   = 1'b1;
        first_empty = 2'(c);
      end
    end
  end

  wkm_pixel_ram u_ram (
    .clk   (clk),
    .we    (in_accept && !pixel_count[ADDR_W]),
    .waddr (pixel_count[ADDR_W-1:0]),
    .wdata ({masked_out, pixel_value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wkm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state, divider requests and input stall
  always_comb begin
    state_next       = state;
    in_stall         = (state != S_LOAD);
    div_req.start    = 1'b0;
    div_req.dividend = {stat_sum, 8'd0};
    div_req.divisor  = n_unmasked;
    case (state)
      S_LOAD: begin
        if (in_accept && last_pixel) begin
          state_next = S_STAT;
        end
      end
      S_STAT: begin
        if (idx >= pixel_count && !rvalid) begin
          state_next = S_STAT_END;
        end
      end
      S_STAT_END: begin
        if (n_unmasked == '0) begin
          state_next = S_ERR;
        end else begin
          div_req.start = 1'b1;
          if (!k_is_two) begin
            div_req.dividend = DIVD_W'(hi - lo);
            div_req.divisor  = DIVS_W'(k_eff + 3'd1);
          end
          state_next = S_INIT_DIV;
        end
      end
      S_INIT_DIV: begin
        if (div_done) begin
          state_next = S_INIT_SET;
        end
      end
      S_INIT_SET: state_next = S_PASS_START;
      S_PASS_START: begin
        state_next = (pass >= max_passes) ? S_EMIT : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_next = (idx >= pixel_count) ? S_CHECK : S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        state_next = ram_rdata[PIXEL_BITS] ? S_SCAN_RD : S_SQ;
      end
      S_SQ:  state_next = S_MUL;
      S_MUL: state_next = S_CMP;
      S_CMP: begin
        state_next = j_last ? S_ACC : S_SQ;
      end
      S_ACC: state_next = S_SCAN_RD;
      S_CHECK: begin
        state_next = any_empty ? S_ERR : S_UPD_DIV;
      end
      S_UPD_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {sums[j], 8'd0};
        div_req.divisor  = counts[j];
        state_next       = S_UPD_WAIT;
      end
      S_UPD_WAIT: begin
        if (div_done) begin
          state_next = j_last ? S_CONV : S_UPD_DIV;
        end
      end
      S_CONV: begin
        state_next = (delta <= {1'b0, conv_limit}) ? S_EMIT : S_PASS_START;
      end
      S_EMIT: begin
        if (out_free && j_last) begin
          state_next = S_LOAD;
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= 3'd2;
      for (int c = 0; c < K_MAX; c++) begin
        weights[c] <= 16'd4096;
      end
      conv_limit <= '0;
      max_passes <= 8'd20;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NUM_CLUSTERS: num_clusters <= cfg_data[2:0];
        CFG_WEIGHT_ZERO:  weights[0]   <= cfg_data[15:0];
        CFG_WEIGHT_ONE:   weights[1]   <= cfg_data[15:0];
        CFG_WEIGHT_TWO:   weights[2]   <= cfg_data[15:0];
        CFG_WEIGHT_THREE: weights[3]   <= cfg_data[15:0];
        CFG_CONV_LIMIT:   conv_limit   <= cfg_data;
        CFG_MAX_PASSES:   max_passes   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // control counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
      idx         <= '0;
      rvalid      <= 1'b0;
      pass        <= '0;
      j           <= '0;
      out_valid   <= 1'b0;
    end else begin
      // output register loads a new transaction or empties when taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_accept) begin
            if (!pixel_count[ADDR_W]) begin
              pixel_count <= pixel_count + 1'b1;
            end
            idx    <= '0;
            rvalid <= 1'b0;
          end
        end
        S_STAT: begin
          // one read per cycle, data handled in the following cycle
          if (idx < pixel_count) begin
            idx    <= idx + 1'b1;
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
          end
        end
        S_INIT_SET: pass <= '0;
        S_PASS_START: begin
          if (pass < max_passes) begin
            pass <= pass + 1'b1;
            idx  <= '0;
          end
          j <= '0;
        end
        S_SCAN_RD: begin
          if (idx < pixel_count) begin
            idx <= idx + 1'b1;
          end
          j <= '0;
        end
        S_CMP: begin
          if (!j_last) begin
            j <= j + 1'b1;
          end
        end
        S_CHECK: j <= '0;
        S_UPD_WAIT: begin
          if (div_done) begin
            j <= j_last ? '0 : j + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            j <= j + 1'b1;
            if (j_last) begin
              pixel_count <= '0;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            pixel_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        n_unmasked <= '0;
        stat_sum   <= '0;
      end
      S_STAT: begin
        if (rvalid && !ram_rdata[PIXEL_BITS]) begin
          if (n_unmasked == '0) begin
            mn <= ram_rdata[PIXEL_BITS-1:0];
            mx <= ram_rdata[PIXEL_BITS-1:0];
          end else if (ram_rdata[PIXEL_BITS-1:0] > mx) begin
            mx <= ram_rdata[PIXEL_BITS-1:0];
          end else if (ram_rdata[PIXEL_BITS-1:0] < mn) begin
            mn <= ram_rdata[PIXEL_BITS-1:0];
          end
          n_unmasked <= n_unmasked + 1'b1;
          stat_sum   <= stat_sum + SUM_W'(ram_rdata[PIXEL_BITS-1:0]);
        end
      end
      S_STAT_END: begin
        err_index  <= '0;
        err_passes <= '0;
        err_status <= STATUS_MASKED;
      end
      S_INIT_SET: begin
        if (k_is_two) begin
          // midpoints toward the average
          means[0] <= lo + ((avg - lo) >> 1);
          means[1] <= avg + ((hi - avg) >> 1);
          means[2] <= '0;
          means[3] <= '0;
        end else begin
          means[0] <= lo + step;
          means[1] <= lo + (step << 1);
          means[2] <= lo + step + (step << 1);
          means[3] <= lo + (step << 2);
        end
      end
      S_PASS_START: begin
        for (int c = 0; c < K_MAX; c++) begin
          prev[c]   <= means[c];
          sums[c]   <= '0;
          counts[c] <= '0;
        end
        delta <= '0;
      end
      S_SCAN_WAIT: pix <= ram_rdata[PIXEL_BITS-1:0];
      S_SQ:  sq <= abs_diff * abs_diff;
      S_MUL: begin
        // weight times square, split in two 16 x 24 products
        plo <= weights[j] * sq[23:0];
        phi <= weights[j] * sq[47:24];
      end
      S_CMP: begin
        // strict compare keeps the lowest index on ties
        if (j == '0 || nd < bd) begin
          bd   <= nd;
          best <= j;
        end
      end
      S_ACC: begin
        sums[best]   <= sums[best] + SUM_W'(pix);
        counts[best] <= counts[best] + 1'b1;
      end
      S_CHECK: begin
        err_index  <= first_empty;
        err_passes <= pass;
        err_status <= STATUS_EMPTY;
        delta      <= '0;
      end
      S_UPD_WAIT: begin
        if (div_done) begin
          means[j] <= new_mean;
          delta    <= delta + DELTA_W'(mean_diff);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cluster_index <= j;
          cluster_mean  <= means[j];
          passes_done   <= pass;
          status        <= STATUS_OK;
          last_result   <= j_last;
        end
      end
      S_ERR: begin
        if (out_free) begin
          cluster_index <= err_index;
          cluster_mean  <= '0;
          passes_done   <= err_passes;
          status        <= err_status;
          last_result   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  `WKM_ASSERT_NEXT(a_last_starts_run, in_accept && last_pixel, state == S_STAT)
  `WKM_ASSERT_NOW(a_cmp_cluster_in_use, state == S_CMP, {1'b0, j} < k_eff)
  `WKM_ASSERT_NOW(a_count_bound, 1'b1, pixel_count <= CNT_W'(MAX_PIXELS))

endmodule
